@@ rtl/latency_window_statistics_assert.svh @@
// ----------------------------------------------------------------------------
// Latency window statistics: assertion macros
// Concurrent assertion wrappers that fall away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LATENCY_WINDOW_STATISTICS_ASSERT_SVH
`define LATENCY_WINDOW_STATISTICS_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define LWS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("latency_window_statistics: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("latency_window_statistics: assertion failed");

`else

`define LWS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LWS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/lws_pkg.sv @@
// ----------------------------------------------------------------------------
// Latency window statistics package
// Field widths, register map, and sequencer states of the latency monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lws_pkg;

    // Fixed field widths.
    localparam int TS_W   = 64;
    localparam int DUR_W  = 48;
    localparam int CNT_W  = 7;
    localparam int STEP_W = 6;

    // Largest duration that a sample can hold.
    localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

    // Default number of samples in the window.
    localparam int DEPTH_DEF = 64;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_ENABLE = 1'b0;

    // Request opcodes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STOP  = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_PREP,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

@@ rtl/latency_window_statistics.sv @@
// ----------------------------------------------------------------------------
// Latency window statistics
// Latency monitor with a moving window average and a peak that never decays.
//
// Requests enter on i_valid/o_ready: a start request stores its timestamp, a
// stop request measures the time since the stored start, clamps it to 48 bits
// and adds it to a ring of the last DEPTH samples. Every request returns one
// result on o_valid/i_ready with the window average, the peak, the sample
// count and the duration of this request (zero for start requests).
// The enable register at byte address 0 of the APB port gates all updates.
// One request is worked on at a time. A start request, or any request while
// disabled, goes from idle straight to the done state, where its result loads
// into the output register. A stop request runs a bit-serial subtract, a
// setup step, a bit-serial sum update and a restoring divide of SUM_W =
// 48 + clog2(DEPTH) bits each, and a load step. The sequencer returns to
// idle, where it takes the next request, in the cycle after the result loads.
// A finished result waits in the output register while the next request is
// taken; when the receiver stalls, the sequencer holds its next result until
// the output register frees. Reset clears the statistics, the stored start
// time and the enable bit; the ring itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "latency_window_statistics_assert.svh"

module latency_window_statistics #(
    parameter int DEPTH = lws_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    // Request channel.
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_opcode,
    input  logic [lws_pkg::TS_W-1:0]   i_timestamp,

    // Result channel.
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [lws_pkg::DUR_W-1:0]  o_average,
    output logic [lws_pkg::DUR_W-1:0]  o_peak,
    output logic [lws_pkg::CNT_W-1:0]  o_sample_count,
    output logic [lws_pkg::DUR_W-1:0]  o_last_duration,
    output logic                       o_saturated,

    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lws_pkg::ADDR_W-1:0] paddr,
    input  logic [lws_pkg::DATA_W-1:0] pwdata,
    output logic [lws_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    import lws_pkg::*;

    localparam int SUM_W  = DUR_W + $clog2(DEPTH);
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HELD_W = $clog2(DEPTH + 1);

    // Control state.
    t_state              r_state;
    t_state              n_state;
    logic [STEP_W-1:0]   r_step;
    logic                r_out_valid;
    logic                r_enable;

    // Statistics state.
    logic [TS_W-1:0]     r_start;
    logic [SLOT_W-1:0]   r_slot;
    logic [HELD_W-1:0]   r_held;
    logic [SUM_W-1:0]    r_sum;
    logic [DUR_W-1:0]    r_peak;
    logic [DUR_W-1:0]    r_average;

    // Serial datapath.
    logic [TS_W-1:0]     r_ts_sh;
    logic [TS_W-1:0]     r_st_sh;
    logic [TS_W-1:0]     r_diff;
    logic                r_sub_bw;
    logic [SUM_W-1:0]    r_dur_sh;
    logic [SUM_W-1:0]    r_old_sh;
    logic                r_add_cy;
    logic                r_add_bw;
    logic [SUM_W-1:0]    r_dvd;
    logic [HELD_W-1:0]   r_rem;
    logic [DUR_W-1:0]    r_dur;
    logic                r_sat;

    // Sample ring.
    logic [DUR_W-1:0]    r_ring [DEPTH];
    logic [DUR_W-1:0]    r_old;

    // Output register.
    logic [DUR_W-1:0]    r_o_average;
    logic [DUR_W-1:0]    r_o_peak;
    logic [CNT_W-1:0]    r_o_count;
    logic [DUR_W-1:0]    r_o_dur;
    logic                r_o_sat;

    // Handshake and control decode.
    logic                accept;
    logic                load_out;
    logic                last_step;
    logic                cfg_write;
    logic                ring_full;

    // Combinational next values of the serial steps.
    logic                n_sub_bit;
    logic                n_sub_bw;
    logic                n_sat;
    logic [DUR_W-1:0]    n_dur;
    logic                n_add_t;
    logic                n_add_cy;
    logic                n_add_bit;
    logic                n_add_bw;
    logic [SUM_W-1:0]    n_sum;
    logic [HELD_W:0]     n_rem_sh;
    logic                n_q;
    logic [HELD_W-1:0]   n_rem;
    logic [SUM_W-1:0]    n_dvd;

    // Handshake outputs.
    always_comb begin
        o_ready   = (r_state == ST_IDLE);
        accept    = i_valid && o_ready;
        load_out  = (r_state == ST_DONE) && (!r_out_valid || i_ready);
        last_step = (r_step == '0);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_enable && (i_opcode == OP_STOP)) begin
                        n_state = ST_SUB;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SUB: begin
                if (last_step) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                if (last_step) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (last_step) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // One bit of the timestamp subtraction, least significant bit first.
    always_comb begin
        n_sub_bit = r_ts_sh[0] ^ r_st_sh[0] ^ r_sub_bw;
        n_sub_bw  = (~r_ts_sh[0] & r_st_sh[0]) |
                    (~(r_ts_sh[0] ^ r_st_sh[0]) & r_sub_bw);
    end

    // Clamp of the finished difference.
    always_comb begin
        n_sat     = |r_diff[TS_W-1:DUR_W];
        n_dur     = n_sat ? DUR_MAX : r_diff[DUR_W-1:0];
        ring_full = (r_held == HELD_W'(DEPTH));
    end

    // One bit of sum + new sample - evicted sample.
    always_comb begin
        n_add_t   = r_sum[0] ^ r_dur_sh[0] ^ r_add_cy;
        n_add_cy  = (r_sum[0] & r_dur_sh[0]) | (r_add_cy & (r_sum[0] ^ r_dur_sh[0]));
        n_add_bit = n_add_t ^ r_old_sh[0] ^ r_add_bw;
        n_add_bw  = (~n_add_t & r_old_sh[0]) | (~(n_add_t ^ r_old_sh[0]) & r_add_bw);
        n_sum     = {n_add_bit, r_sum[SUM_W-1:1]};
    end

    // One step of the restoring divide of the window sum by the count.
    always_comb begin
        n_rem_sh = {r_rem, r_dvd[SUM_W-1]};
        n_q      = (n_rem_sh >= {1'b0, r_held});
        n_rem    = n_q ? HELD_W'(n_rem_sh - {1'b0, r_held}) : n_rem_sh[HELD_W-1:0];
        n_dvd    = {r_dvd[SUM_W-2:0], n_q};
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Step counter of the serial phases.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: r_step <= STEP_W'(TS_W - 1);
                ST_PREP: r_step <= STEP_W'(SUM_W - 1);
                ST_SUM: begin
                    r_step <= last_step ? STEP_W'(SUM_W - 1) : r_step - 1'b1;
                end
                default: r_step <= r_step - 1'b1;
            endcase
        end
    end

    // Configuration register.
    always_comb begin
        pready    = 1'b1;
        cfg_write = psel && penable && pwrite && pready;
        prdata    = (paddr[2] == REG_ENABLE) ? DATA_W'(r_enable) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (cfg_write && (paddr[2] == REG_ENABLE)) begin
            r_enable <= pwdata[0];
        end
    end

    // Statistics that reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_slot    <= '0;
            r_held    <= '0;
            r_sum     <= '0;
            r_peak    <= '0;
            r_average <= '0;
        end else begin
            if (accept && r_enable && (i_opcode == OP_START)) begin
                r_start <= i_timestamp;
            end
            if (r_state == ST_PREP) begin
                r_slot <= (r_slot == SLOT_W'(DEPTH - 1)) ? '0 : r_slot + 1'b1;
                if (!ring_full) begin
                    r_held <= r_held + 1'b1;
                end
                if (n_dur > r_peak) begin
                    r_peak <= n_dur;
                end
            end
            if (r_state == ST_SUM) begin
                r_sum <= n_sum;
            end
            if ((r_state == ST_DIV) && last_step) begin
                r_average <= n_dvd[DUR_W-1:0];
            end
        end
    end

    // Serial datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_ts_sh  <= i_timestamp;
                r_st_sh  <= r_start;
                r_sub_bw <= 1'b0;
                r_dur    <= '0;
                r_sat    <= 1'b0;
            end
            ST_SUB: begin
                r_ts_sh  <= {1'b0, r_ts_sh[TS_W-1:1]};
                r_st_sh  <= {1'b0, r_st_sh[TS_W-1:1]};
                r_diff   <= {n_sub_bit, r_diff[TS_W-1:1]};
                r_sub_bw <= n_sub_bw;
            end
            ST_PREP: begin
                r_dur    <= n_dur;
                r_sat    <= n_sat;
                r_dur_sh <= SUM_W'(n_dur);
                r_old_sh <= ring_full ? SUM_W'(r_old) : '0;
                r_add_cy <= 1'b0;
                r_add_bw <= 1'b0;
            end
            ST_SUM: begin
                r_dur_sh <= {1'b0, r_dur_sh[SUM_W-1:1]};
                r_old_sh <= {1'b0, r_old_sh[SUM_W-1:1]};
                r_add_cy <= n_add_cy;
                r_add_bw <= n_add_bw;
                if (last_step) begin
                    r_dvd <= n_sum;
                    r_rem <= '0;
                end
            end
            ST_DIV: begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
            end
            ST_DONE: begin
                r_dur <= r_dur;
            end
            default: begin
                r_sat <= r_sat;
            end
        endcase
    end

    // Sample ring: the oldest entry is read while the subtraction runs.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP) begin
            r_ring[r_slot] <= n_dur;
        end
        r_old <= r_ring[r_slot];
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_average <= r_average;
            r_o_peak    <= r_peak;
            r_o_count   <= CNT_W'(r_held);
            r_o_dur     <= r_dur;
            r_o_sat     <= r_sat;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_average       = r_o_average;
    assign o_peak          = r_o_peak;
    assign o_sample_count  = r_o_count;
    assign o_last_duration = r_o_dur;
    assign o_saturated     = r_o_sat;

    // The sample count never passes the window depth.
    `LWS_ASSERT_IMPLY(a_held_bound, i_clk, i_rst_n, 1'b1, r_held <= HELD_W'(DEPTH))

    // The divider never runs with an empty window.
    `LWS_ASSERT_IMPLY(a_div_nonzero, i_clk, i_rst_n, r_state == ST_DIV, r_held != '0)

    // A request taken while disabled goes straight to its result.
    `LWS_ASSERT_NEXT(a_disabled_fast, i_clk, i_rst_n, accept && !r_enable, r_state == ST_DONE)

    // A stop request while enabled starts the serial subtraction.
    `LWS_ASSERT_NEXT(a_stop_runs, i_clk, i_rst_n,
        accept && r_enable && (i_opcode == OP_STOP), r_state == ST_SUB)

endmodule
